@@ rtl/core/swm_pkg.sv @@
`default_nettype none
package swm_pkg;

    localparam int WORD_W = 32;
    localparam int CFG_W  = 7;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic [CFG_W-1:0]         cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_BUSY = 3'b010,
        ST_LOAD = 3'b100
    } state_t;

endpackage
`default_nettype wire

@@ rtl/core/swm_cell.sv @@
`default_nettype none
module swm_cell (
    input  wire logic          clk,
    input  wire logic          shift_en,
    input  wire logic          active,
    input  wire swm_pkg::word_t data_in,
    input  wire swm_pkg::word_t max_in,
    output swm_pkg::word_t     data_out,
    output swm_pkg::word_t     max_out
);
    import swm_pkg::*;

    word_t data_reg;
    word_t max_reg;
    word_t max_next;

    // running maximum ripples one cell per cycle
    assign max_next = (active && (data_reg > max_in)) ? data_reg : max_in;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            data_reg <= data_in;
        end
        max_reg <= max_next;
    end

    assign data_out = data_reg;
    assign max_out  = max_reg;

endmodule
`default_nettype wire

@@ rtl/core/sliding_window_maximum.sv @@
// Sliding window maximum over a stream of signed 32-bit samples.
// Input channel: sample, first, sample_valid / sample_ready. first opens a
// new sequence and drops the fill count. Output channel: window_max,
// max_valid / max_ready. Configuration: cfg_wr_en / cfg_wr_data write the
// window size (0 acts as 1, above WINDOW_MAX acts as WINDOW_MAX).
// Samples live in a row of WINDOW_MAX cells; an accepted word shifts the row
// and a running maximum then ripples through the cells, one per cycle.
// A sample that completes a window takes the control from IDLE through BUSY,
// while the maximum ripples, to LOAD, where the result enters the output
// register and raises max_valid; sample_ready stays low until the control
// is back in IDLE. A sample that does not yet complete a window yields
// nothing and the next sample may follow in the next cycle.
// The result sits in an output register: while the receiver stalls, one
// result waits there and the next sample is still taken and processed; the
// one after that waits until the register drains.
// Reset clears the fill count, the control state and the output valid flag,
// and sets the window size to 1. Sample storage is not reset; only entries
// written in the current sequence are ever compared.
`default_nettype none
module sliding_window_maximum #(
    parameter int WINDOW_MAX = 64
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_wr_en,
    input  wire swm_pkg::cfg_t cfg_wr_data,
    input  wire swm_pkg::word_t sample,
    input  wire logic          first,
    input  wire logic          sample_valid,
    output logic               sample_ready,
    output swm_pkg::word_t     window_max,
    output logic               max_valid,
    input  wire logic          max_ready
);
    import swm_pkg::*;

    localparam int CW    = $clog2(WINDOW_MAX + 1);
    localparam int SW    = (CW > CFG_W) ? CW : CFG_W;
    localparam int CNT_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

    cfg_t            window_size_reg;
    logic [CW-1:0]   size_reg, size_next;
    logic [CW-1:0]   fill_reg, fill_next, fill_base;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    state_t          state_reg, state_next;
    word_t           out_reg, out_next;
    logic            out_valid_reg, out_valid_next;
    logic [SW-1:0]   wsz_ext;
    logic            accept, emit, load;

    word_t           chain_data [WINDOW_MAX+1];
    word_t           chain_max  [WINDOW_MAX+1];
    logic [WINDOW_MAX-1:0] active;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= CFG_W'(1);
        end
        else if (cfg_wr_en)
        begin
            window_size_reg <= cfg_wr_data;
        end
    end

    always_comb
    begin
        wsz_ext = SW'(window_size_reg);
        if (wsz_ext == '0)
        begin
            size_next = CW'(1);
        end
        else if (wsz_ext > SW'(WINDOW_MAX))
        begin
            size_next = CW'(WINDOW_MAX);
        end
        else
        begin
            size_next = wsz_ext[CW-1:0];
        end
    end

    assign sample_ready = (state_reg == ST_IDLE);
    assign accept       = sample_valid && sample_ready;
    assign fill_base    = first ? '0 : fill_reg;
    assign fill_next    = (fill_base < CW'(WINDOW_MAX)) ? fill_base + CW'(1) : fill_base;
    assign emit         = (fill_next >= size_next);
    assign load         = (state_reg == ST_LOAD) && (!out_valid_reg || max_ready);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && max_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && emit)
                begin
                    state_next = ST_BUSY;
                    cnt_next   = '0;
                end
            end
            ST_BUSY:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(WINDOW_MAX - 1))
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (load)
                begin
                    out_next       = chain_max[WINDOW_MAX];
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            fill_reg      <= '0;
            size_reg      <= CW'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                fill_reg <= fill_next;
                size_reg <= size_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign chain_data[0] = sample;
    assign chain_max[0]  = {1'b1, {(WORD_W-1){1'b0}}};

    for (genvar i = 0; i < WINDOW_MAX; i++)
    begin : g_cell
        assign active[i] = (CW'(i) < size_reg);

        swm_cell u_cell (
            .clk      (clk),
            .shift_en (accept),
            .active   (active[i]),
            .data_in  (chain_data[i]),
            .max_in   (chain_max[i]),
            .data_out (chain_data[i+1]),
            .max_out  (chain_max[i+1])
        );
    end

    assign window_max = out_reg;
    assign max_valid  = out_valid_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(WINDOW_MAX))
        else $error("fill count above window capacity");

    a_no_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !emit) |=> (state_reg == ST_IDLE))
        else $error("sample without result left the block busy");

    a_max_ge_newest: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (max_valid && (window_max >= $past(chain_data[1]))))
        else $error("window maximum below newest sample");

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BUSY) |-> (!sample_ready && !load))
        else $error("input taken or result loaded during ripple");

endmodule
`default_nettype wire
